>>> design/label_mask_interface_classifier_assert.svh
// assertion helpers, clocked on i_clk and disabled while i_rst_n is low
`ifndef LABEL_MASK_INTERFACE_CLASSIFIER_ASSERT_SVH
`define LABEL_MASK_INTERFACE_CLASSIFIER_ASSERT_SVH

// condition holds at every edge
`define LMIC_ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) \
        else $error(msg);

// consequent holds in the cycle after the antecedent
`define LMIC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> design/lmic_pkg.sv
`timescale 1ns / 1ps

package lmic_pkg;

    localparam int LABEL_W = 8;
    localparam int FW_W    = 11;
    localparam int FH_W    = 16;
    localparam int APB_AW  = 5;
    localparam int APB_DW  = 32;

    // class code held in the line buffer
    typedef enum logic [1:0] {
        CLS_NONE  = 2'd0,
        CLS_WATER = 2'd1,
        CLS_CLAY  = 2'd2,
        CLS_GAS   = 2'd3
    } t_class;

    typedef enum logic [2:0] {
        REG_FRAME_WIDTH  = 3'd0,
        REG_FRAME_HEIGHT = 3'd1,
        REG_CLAY_LAB     = 3'd2,
        REG_WATER_LAB    = 3'd3,
        REG_GAS_LAB      = 3'd4
    } t_reg_idx;

    typedef struct packed {
        logic               req_type;
        logic [LABEL_W-1:0] pixel_label;
    } t_in_word;

    typedef struct packed {
        logic is_active;
        logic is_clay;
        logic is_interface;
        logic end_of_frame;
    } t_out_word;

    // first match wins: water, clay, gas
    function automatic t_class f_classify(
        input logic [LABEL_W-1:0] lab,
        input logic [LABEL_W-1:0] water,
        input logic [LABEL_W-1:0] clay,
        input logic [LABEL_W-1:0] gas
    );
        t_class k;
        if (lab == water) begin
            k = CLS_WATER;
        end else if (lab == clay) begin
            k = CLS_CLAY;
        end else if (lab == gas) begin
            k = CLS_GAS;
        end else begin
            k = CLS_NONE;
        end
        return k;
    endfunction

    function automatic logic f_is_clay(
        input t_class             k,
        input logic [LABEL_W-1:0] water,
        input logic [LABEL_W-1:0] clay
    );
        return (k == CLS_CLAY) || ((k == CLS_WATER) && (water == clay));
    endfunction

    function automatic logic f_is_gas(
        input t_class             k,
        input logic [LABEL_W-1:0] water,
        input logic [LABEL_W-1:0] clay,
        input logic [LABEL_W-1:0] gas
    );
        return (k == CLS_GAS) || ((k == CLS_WATER) && (water == gas)) ||
               ((k == CLS_CLAY) && (clay == gas));
    endfunction

endpackage

>>> design/lmic_stream_if.sv
`timescale 1ns / 1ps

interface lmic_stream_if
    import lmic_pkg::*;
#(
    parameter type T = t_in_word
) ();
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

>>> design/lmic_ram.sv
`timescale 1ns / 1ps

module lmic_ram #(
    parameter int WIDTH = 3,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr_a,
    input  logic [$clog2(DEPTH)-1:0] i_raddr_b,
    output logic [WIDTH-1:0]         o_rdata_a,
    output logic [WIDTH-1:0]         o_rdata_b
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata_a;
    logic [WIDTH-1:0] r_rdata_b;

    // read returns the old contents on a same-address write
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata_a <= r_mem[i_raddr_a];
            r_rdata_b <= r_mem[i_raddr_b];
        end
    end

    assign o_rdata_a = r_rdata_a;
    assign o_rdata_b = r_rdata_b;
endmodule

>>> design/label_mask_interface_classifier.sv
`timescale 1ns / 1ps

// channel   dir   modport  word        fields
// i_pix     in    sink     t_in_word   req_type, pixel_label
// o_res     out   source   t_out_word  is_active, is_clay, is_interface, end_of_frame
// apb       in    -        32-bit      frame_width, frame_height, clay/water/gas labels
//
// one word per cycle sustained unless the result register stalls; a result enters the output
// register from stage 2, which holds the word releasing it (the pixel below, or a flush word)
// the line buffer ram has two read ports and one write port, so the centre/right reads and
// the write back of a column proceed together
// synchronous active-low reset clears counters and handshake state; the line buffer
// has no clearing pass, every entry is written one row before its contents are used
// a stalled result register holds an emitting second stage, which in turn drops i_pix.ready

module label_mask_interface_classifier
    import lmic_pkg::*;
#(
    parameter int MAX_WIDTH = 1024
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    lmic_stream_if.sink       i_pix,
    lmic_stream_if.source     o_res,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready
);
    localparam int AW    = $clog2(MAX_WIDTH);  // column / ram address bits
    localparam int CW    = AW + 1;             // holds the clamped width itself
    localparam int MEM_W = 3;                  // {gas of row above middle, class code}

    // ------------------------------------------------------------------
    // configuration registers
    // ------------------------------------------------------------------
    logic [FW_W-1:0]    r_frame_width;
    logic [FH_W-1:0]    r_frame_height;
    logic [LABEL_W-1:0] r_clay_lab;
    logic [LABEL_W-1:0] r_water_lab;
    logic [LABEL_W-1:0] r_gas_lab;

    logic     cfg_wr;
    t_reg_idx cfg_idx;

    assign cfg_wr  = psel && penable && pwrite;
    assign cfg_idx = t_reg_idx'(paddr[APB_AW-1:2]);
    assign pready  = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_width  <= FW_W'(1024);
            r_frame_height <= FH_W'(1);
            r_clay_lab     <= '0;
            r_water_lab    <= '0;
            r_gas_lab      <= '0;
        end else if (cfg_wr) begin
            unique case (cfg_idx)
                REG_FRAME_WIDTH:  r_frame_width  <= pwdata[FW_W-1:0];
                REG_FRAME_HEIGHT: r_frame_height <= pwdata[FH_W-1:0];
                REG_CLAY_LAB:     r_clay_lab     <= pwdata[LABEL_W-1:0];
                REG_WATER_LAB:    r_water_lab    <= pwdata[LABEL_W-1:0];
                REG_GAS_LAB:      r_gas_lab      <= pwdata[LABEL_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (cfg_idx)
            REG_FRAME_WIDTH:  prdata = APB_DW'(r_frame_width);
            REG_FRAME_HEIGHT: prdata = APB_DW'(r_frame_height);
            REG_CLAY_LAB:     prdata = APB_DW'(r_clay_lab);
            REG_WATER_LAB:    prdata = APB_DW'(r_water_lab);
            REG_GAS_LAB:      prdata = APB_DW'(r_gas_lab);
            default:          prdata = '0;
        endcase
    end

    // width clamped to 1..MAX_WIDTH, height zero taken as one
    logic [CW-1:0]   w_eff;
    logic [FH_W-1:0] h_eff;

    always_comb begin
        if (r_frame_width == '0) begin
            w_eff = CW'(1);
        end else if (32'(r_frame_width) > 32'(MAX_WIDTH)) begin
            w_eff = CW'(MAX_WIDTH);
        end else begin
            w_eff = CW'(r_frame_width);
        end
        h_eff = (r_frame_height == '0) ? FH_W'(1) : r_frame_height;
    end

    // ------------------------------------------------------------------
    // stage 1: position counters, word accept, ram read issue
    // ------------------------------------------------------------------
    logic [AW-1:0]   r_col;
    logic [FH_W-1:0] r_row;

    logic          flushing;   // all pixels in, only flush words expected
    logic          last_col;
    logic [AW-1:0] col_inc;
    logic          take;       // accepted word that the frame expects
    t_class        s1_newk;

    assign flushing = (r_row >= h_eff);
    assign last_col = ((CW'(r_col) + CW'(1)) >= w_eff);
    assign col_inc  = r_col + AW'(1);
    assign take     = i_pix.valid && i_pix.ready && (i_pix.data.req_type == flushing);
    assign s1_newk  = flushing ? CLS_NONE :
                      f_classify(i_pix.data.pixel_label, r_water_lab, r_clay_lab,
                                 r_gas_lab);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else if (take) begin
            if (last_col) begin
                r_col <= '0;
                // frame end after the last flush word of the final row
                r_row <= flushing ? '0 : r_row + FH_W'(1);
            end else begin
                r_col <= col_inc;
            end
        end
    end

    // ------------------------------------------------------------------
    // stage 2 registers
    // ------------------------------------------------------------------
    logic             r_s2_valid;
    logic [AW-1:0]    r_s2_col;
    logic             r_s2_last;
    logic             r_s2_flush;
    logic             r_s2_emit;     // row >= 1: this word releases the pixel above
    logic             r_s2_up_en;    // row >= 2: upper row gas is valid
    logic             r_s2_left_en;  // column > 0
    t_class           r_s2_newk;
    logic             r_fwd_a;       // centre / upper read hits the write in flight
    logic             r_fwd_b;       // right read hits the write in flight
    logic [MEM_W-1:0] r_fwd_data;
    t_class           r_prev_centre; // centre of the last word, left of the next

    logic             s2_adv;
    logic             s2_wr;
    logic [MEM_W-1:0] s2_wdata;
    logic             n_fwd_a;
    logic             n_fwd_b;

    // an emitting stage 2 may move only into a free or draining result register
    assign s2_adv      = !r_s2_emit || !o_res.valid || o_res.ready;
    assign i_pix.ready = !r_s2_valid || s2_adv;
    assign s2_wr       = r_s2_valid && s2_adv && !r_s2_flush;

    // stage 2 writes at the same edge that the new reads are sampled
    assign n_fwd_a = r_s2_valid && !r_s2_flush && (r_col == r_s2_col);
    assign n_fwd_b = r_s2_valid && !r_s2_flush && !last_col && (col_inc == r_s2_col);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
        end else if (i_pix.ready) begin
            r_s2_valid <= take;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_s2_col     <= r_col;
            r_s2_last    <= last_col;
            r_s2_flush   <= flushing;
            r_s2_emit    <= (r_row != '0);
            r_s2_up_en   <= (r_row >= FH_W'(2));
            r_s2_left_en <= (r_col != '0);
            r_s2_newk    <= s1_newk;
            r_fwd_a      <= n_fwd_a;
            r_fwd_b      <= n_fwd_b;
            r_fwd_data   <= s2_wdata;
        end
    end

    // ------------------------------------------------------------------
    // line buffer: class of the middle row and gas flag of the upper row
    // ------------------------------------------------------------------
    logic [MEM_W-1:0] rd_a;
    logic [MEM_W-1:0] rd_b;

    lmic_ram #(
        .WIDTH (MEM_W),
        .DEPTH (MAX_WIDTH)
    ) u_line_buf (
        .i_clk     (i_clk),
        .i_we      (s2_wr),
        .i_waddr   (r_s2_col),
        .i_wdata   (s2_wdata),
        .i_re      (take),
        .i_raddr_a (r_col),
        .i_raddr_b (col_inc),
        .o_rdata_a (rd_a),
        .o_rdata_b (rd_b)
    );

    // ------------------------------------------------------------------
    // stage 2: decode window, form result, write back
    // ------------------------------------------------------------------
    t_class    centre;
    t_class    right;
    logic      up_gas;
    logic      down_gas;
    logic      side_gas;
    logic      is_water;
    logic      is_clay;
    t_out_word s2_word;

    always_comb begin
        centre   = r_fwd_a ? t_class'(r_fwd_data[1:0]) : t_class'(rd_a[1:0]);
        right    = r_fwd_b ? t_class'(r_fwd_data[1:0]) : t_class'(rd_b[1:0]);
        up_gas   = r_s2_up_en && (r_fwd_a ? r_fwd_data[2] : rd_a[2]);
        down_gas = !r_s2_flush &&
                   f_is_gas(r_s2_newk, r_water_lab, r_clay_lab, r_gas_lab);
        side_gas = (r_s2_left_en &&
                    f_is_gas(r_prev_centre, r_water_lab, r_clay_lab, r_gas_lab)) ||
                   (!r_s2_last &&
                    f_is_gas(right, r_water_lab, r_clay_lab, r_gas_lab));
        is_water = (centre == CLS_WATER);
        is_clay  = f_is_clay(centre, r_water_lab, r_clay_lab);

        s2_word.is_active    = is_water || is_clay;
        s2_word.is_clay      = is_clay;
        s2_word.is_interface = is_water && (side_gas || up_gas || down_gas);
        s2_word.end_of_frame = r_s2_flush && r_s2_last;

        // gas flag of centre moves up to become the upper row, the new pixel becomes middle
        s2_wdata = {f_is_gas(centre, r_water_lab, r_clay_lab, r_gas_lab), r_s2_newk};
    end

    always_ff @(posedge i_clk) begin
        if (r_s2_valid && s2_adv) begin
            r_prev_centre <= centre;
        end
    end

    // ------------------------------------------------------------------
    // result register
    // ------------------------------------------------------------------
    logic      r_out_valid;
    t_out_word r_out_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_s2_valid && r_s2_emit && s2_adv) begin
            r_out_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_s2_valid && r_s2_emit && s2_adv) begin
            r_out_data <= s2_word;
        end
    end

    assign o_res.valid = r_out_valid;
    assign o_res.data  = r_out_data;

    // ------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------
`include "label_mask_interface_classifier_assert.svh"

    `LMIC_ASSERT_ALWAYS(a_fwd_excl, !(r_s2_valid && r_fwd_a && r_fwd_b), "both forwards set")
    `LMIC_ASSERT_ALWAYS(a_col_range, 32'(r_col) < 32'(MAX_WIDTH), "column past line buffer")
    `LMIC_ASSERT_NEXT(a_s2_hold, r_s2_valid && !s2_adv, r_s2_valid && $stable(r_s2_col), "s2 lost")
    `LMIC_ASSERT_NEXT(a_frame_end, take && flushing && last_col, ~|{r_col, r_row}, "frame end")
    `LMIC_ASSERT_NEXT(a_row0_silent, take && ~|r_row, r_s2_valid && !r_s2_emit, "row 0 emits")

endmodule
